// ===== hdl/rffp_pkg.sv =====
package rffp_pkg;

	// Parser phase, one-hot
	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_ID      = 6'b000010,
		PH_CMD     = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_TRAIL   = 6'b100000
	} phase_t;

	// Result item kinds
	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_ID       = 3'd1;
	localparam logic [2:0] KIND_CMD      = 3'd2;
	localparam logic [2:0] KIND_LEN      = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd4;
	localparam logic [2:0] KIND_TRAIL    = 3'd5;
	localparam logic [2:0] KIND_CHECKSUM = 3'd6;

	// Frame status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_SHORT     = 2'd1;
	localparam logic [1:0] STAT_CSUM_ERR  = 2'd2;
	localparam logic [1:0] STAT_TRUNCATED = 2'd3;

	// Headers with a fixed id count
	localparam logic [7:0] HDR_ONE_ID  = 8'h14;
	localparam logic [7:0] HDR_TWO_A   = 8'h18;
	localparam logic [7:0] HDR_TWO_B   = 8'h1c;
	localparam logic [7:0] HDR_TWO_C   = 8'h10;
	localparam logic [7:0] HDR_TWO_D   = 8'h3c;
	localparam logic [7:0] HDR_TWO_E   = 8'h0c;
	localparam logic [7:0] HDR_TWO_F   = 8'h2c;

	// Frames of this many bytes or fewer are too short
	localparam logic [2:0] SHORT_LIMIT = 3'd4;
	// Byte counter saturation
	localparam logic [2:0] SEEN_MAX    = 3'd5;
	// Last byte index within a 24-bit id
	localparam logic [1:0] ID_LAST_BYTE = 2'd2;

	typedef struct packed {
		logic [2:0]  item_kind;
		logic [23:0] field_value;
		logic        field_complete;
		logic [7:0]  field_index;
		logic        frame_done;
		logic [1:0]  frame_status;
	} result_t;

	// Number of device ids announced by a header byte
	function automatic logic [1:0] ids_for_header(input logic [7:0] h);
		logic [1:0] n;
		case (h)
			HDR_ONE_ID: n = 2'd1;
			HDR_TWO_A, HDR_TWO_B, HDR_TWO_C,
			HDR_TWO_D, HDR_TWO_E, HDR_TWO_F: n = 2'd2;
			default: n = h[3:2];
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/rffp_if.sv =====
// Input channel: one frame byte per item
interface rffp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// Output channel: one tagged result per item
interface rffp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [23:0] field_value;
	logic        field_complete;
	logic [7:0]  field_index;
	logic        frame_done;
	logic [1:0]  frame_status;

	modport source (output valid, output item_kind, output field_value,
		output field_complete, output field_index, output frame_done,
		output frame_status, input ready);
	modport sink   (input valid, input item_kind, input field_value,
		input field_complete, input field_index, input frame_done,
		input frame_status, output ready);
endinterface

// ===== hdl/rffp_parse.sv =====
module rffp_parse
	import rffp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  ids_left_q, ids_left_d;
	logic [1:0]  id_number_q, id_number_d;
	logic [1:0]  byte_in_field_q, byte_in_field_d;
	logic [23:0] assembled_q, assembled_d;
	logic [7:0]  payload_left_q, payload_left_d;
	logic [7:0]  payload_pos_q, payload_pos_d;
	logic [7:0]  sum_q, sum_next;
	logic [2:0]  seen_q, seen_next;
	logic [1:0]  ids_dec;
	logic [7:0]  left_dec;

	assign sum_next  = sum_q + data_byte;
	assign seen_next = (seen_q < SEEN_MAX) ? seen_q + 3'd1 : seen_q;
	assign ids_dec   = ids_left_q - 2'd1;
	assign left_dec  = payload_left_q - 8'd1;

	// Result and next state for the byte at hand
	always_comb begin
		res = '0;
		res.field_value = {16'd0, data_byte};
		phase_d         = phase_q;
		ids_left_d      = ids_left_q;
		id_number_d     = id_number_q;
		byte_in_field_d = byte_in_field_q;
		assembled_d     = assembled_q;
		payload_left_d  = payload_left_q;
		payload_pos_d   = payload_pos_q;
		if (frame_end) begin
			res.item_kind  = KIND_CHECKSUM;
			res.frame_done = 1'b1;
			if (seen_next <= SHORT_LIMIT)
				res.frame_status = STAT_SHORT;
			else if (sum_next != 8'd0)
				res.frame_status = STAT_CSUM_ERR;
			else if (phase_q != PH_TRAIL)
				res.frame_status = STAT_TRUNCATED;
			else
				res.frame_status = STAT_OK;
			// back to reset state for the next frame
			phase_d         = PH_HEADER;
			ids_left_d      = '0;
			id_number_d     = '0;
			byte_in_field_d = '0;
			assembled_d     = '0;
			payload_left_d  = '0;
			payload_pos_d   = '0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					res.item_kind      = KIND_HEADER;
					res.field_complete = 1'b1;
					ids_left_d         = ids_for_header(data_byte);
					id_number_d        = '0;
					byte_in_field_d    = '0;
					assembled_d        = '0;
					phase_d = (ids_for_header(data_byte) != 2'd0) ? PH_ID : PH_CMD;
				end
				PH_ID: begin
					res.item_kind   = KIND_ID;
					res.field_index = {6'd0, id_number_q};
					if (byte_in_field_q == 2'd0)
						assembled_d = {16'd0, data_byte};
					else
						assembled_d = {assembled_q[15:0], data_byte};
					res.field_value = assembled_d;
					if (byte_in_field_q >= ID_LAST_BYTE) begin
						res.field_complete = 1'b1;
						byte_in_field_d    = '0;
						ids_left_d         = ids_dec;
						id_number_d        = id_number_q + 2'd1;
						if (ids_dec == 2'd0)
							phase_d = PH_CMD;
					end else begin
						byte_in_field_d = byte_in_field_q + 2'd1;
					end
				end
				PH_CMD: begin
					res.item_kind = KIND_CMD;
					if (byte_in_field_q == 2'd0) begin
						assembled_d     = {16'd0, data_byte};
						byte_in_field_d = 2'd1;
					end else begin
						assembled_d        = {8'd0, assembled_q[7:0], data_byte};
						res.field_complete = 1'b1;
						byte_in_field_d    = '0;
						phase_d            = PH_LEN;
					end
					res.field_value = assembled_d;
				end
				PH_LEN: begin
					res.item_kind      = KIND_LEN;
					res.field_complete = 1'b1;
					payload_left_d     = data_byte;
					payload_pos_d      = '0;
					phase_d = (data_byte != 8'd0) ? PH_PAYLOAD : PH_TRAIL;
				end
				PH_PAYLOAD: begin
					res.item_kind      = KIND_PAYLOAD;
					res.field_complete = 1'b1;
					res.field_index    = payload_pos_q;
					payload_pos_d      = payload_pos_q + 8'd1;
					payload_left_d     = left_dec;
					if (left_dec == 8'd0)
						phase_d = PH_TRAIL;
				end
				default: begin
					res.item_kind = KIND_TRAIL;
					phase_d       = PH_TRAIL;
				end
			endcase
		end
	end

	// Parser state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			ids_left_q      <= '0;
			id_number_q     <= '0;
			byte_in_field_q <= '0;
			assembled_q     <= '0;
			payload_left_q  <= '0;
			payload_pos_q   <= '0;
			sum_q           <= '0;
			seen_q          <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			ids_left_q      <= ids_left_d;
			id_number_q     <= id_number_d;
			byte_in_field_q <= byte_in_field_d;
			assembled_q     <= assembled_d;
			payload_left_q  <= payload_left_d;
			payload_pos_q   <= payload_pos_d;
			sum_q           <= frame_end ? 8'd0 : sum_next;
			seen_q          <= frame_end ? 3'd0 : seen_next;
		end
	end

endmodule

// ===== hdl/radio_frame_field_parser_core.sv =====
// Radio frame field parser. Takes one frame byte per item, the checksum byte
// marked by frame_end, and gives exactly one tagged result per byte: header,
// device id bytes (value assembled so far), command bytes, length, payload,
// trailing bytes, and on the last byte the checksum with the frame status
// (ok, too short, checksum error, truncated). Fields are reported as they
// arrive; only the final status confirms the frame. Each byte passes through
// an input register and a result register, with the parser state update
// between the two; one item is taken every cycle while the output is not
// stalled. A stalled output fills both registers before input ready drops.
module radio_frame_field_parser_core
	import rffp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rffp_in_if.sink   frame,
	rffp_out_if.source result
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       frame_end_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;

	// Stage 1 moves on when the result register is free or being emptied
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign frame.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			data_byte_s1 <= frame.data_byte;
			frame_end_s1 <= frame.frame_end;
		end
	end

	rffp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_byte_s1),
		.frame_end (frame_end_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid          = valid_s2;
	assign result.item_kind      = res_s2.item_kind;
	assign result.field_value    = res_s2.field_value;
	assign result.field_complete = res_s2.field_complete;
	assign result.field_index    = res_s2.field_index;
	assign result.frame_done     = res_s2.frame_done;
	assign result.frame_status   = res_s2.frame_status;

endmodule
